[sv/tdc_subevent_hit_decoder_macros.svh]
// ----------------------------------------------------------------------------
// TDC subevent hit decoder assertion macros
// Shorthand for clocked assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef TDC_SUBEVENT_HIT_DECODER_MACROS_SVH
`define TDC_SUBEVENT_HIT_DECODER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define TSH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define TSH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tsh_pkg.sv]
// ----------------------------------------------------------------------------
// TDC subevent hit decoder package
// Shared constants, queue item type and helper functions.
// ----------------------------------------------------------------------------
package tsh_pkg;

    // Configuration register indexes
    localparam logic REG_TIME_WINDOW  = 1'b0;
    localparam logic REG_MARKING_CODE = 1'b1;

    localparam int CFG_DATA_W = 40;

    localparam logic [39:0] TIME_WINDOW_RST  = 40'd10000000;
    localparam logic [31:0] MARKING_CODE_RST = 32'h0002_0003;

    // Stream identifiers
    localparam logic [15:0] TRAILER_ID = 16'h5555;
    localparam logic [15:0] SCI_TDC    = 16'h6500;
    localparam logic [15:0] TUBE_TDC_A = 16'h6400;
    localparam logic [15:0] TUBE_TDC_B = 16'h6410;
    localparam logic [15:0] TUBE_TDC_C = 16'h6411;
    localparam logic [15:0] TUBE_TDC_D = 16'h6420;
    localparam logic [15:0] TUBE_TDC_E = 16'h6430;
    localparam logic [15:0] TUBE_TDC_F = 16'h6431;

    localparam logic [3:0] NIB_HIT   = 4'h8;
    localparam logic [3:0] NIB_EPOCH = 4'h6;

    // Coarse clock period in 10 ps units
    localparam logic [8:0] COARSE_SCALE = 9'd500;

    // Result kinds
    localparam logic [1:0] KIND_TUBE_REF = 2'd0;
    localparam logic [1:0] KIND_SCI_REF  = 2'd1;
    localparam logic [1:0] KIND_SCI_LEAD = 2'd2;
    localparam logic [1:0] KIND_PAIRED   = 2'd3;

    // Queue between framing and hit logic
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic        clear;    // subevent start: drop reference and held rise
        logic [31:0] base;     // epoch<<11 plus coarse, already wrapped
        logic [9:0]  fine;
        logic [6:0]  channel;
        logic        rising;
        logic [15:0] tdc;
        logic [31:0] trigger;
        logic        marked;
    } entry_t;

    function automatic logic is_tube_ref(input logic [15:0] id);
        return id inside {TUBE_TDC_A, TUBE_TDC_B, TUBE_TDC_C,
                          TUBE_TDC_D, TUBE_TDC_E, TUBE_TDC_F};
    endfunction

endpackage

[sv/tsh_front.sv]
// ----------------------------------------------------------------------------
// TDC subevent hit decoder front end
// Walks the subevent framing and queues hit and subevent-start items.
// ----------------------------------------------------------------------------
module tsh_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          word,
    input  logic                 queue_start,
    input  logic [31:0]          marking_code,
    input  logic                 q_full,
    output logic                 push,
    output tsh_pkg::entry_t      push_entry
);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_TDCHDR  = 3'd1;
    localparam logic [2:0] PH_DATA    = 3'd2;
    localparam logic [2:0] PH_TRAILER = 3'd3;
    localparam logic [2:0] PH_PAD     = 3'd4;

    localparam logic [1:0] HDR_SIZE     = 2'd0;
    localparam logic [1:0] HDR_DECODING = 2'd1;
    localparam logic [1:0] HDR_ID       = 2'd2;
    localparam logic [1:0] HDR_TRIGGER  = 2'd3;

    logic [2:0]  phase_reg, phase_next, phase_eff;
    logic [1:0]  hidx_reg, hidx_next, hidx_eff;
    logic        size_odd_reg, size_odd_next;
    logic [15:0] words_left_reg, words_left_next, words_left_dec;
    logic [15:0] tdc_reg, tdc_next;
    logic [31:0] trigger_reg, trigger_next;
    logic        mark_reg, mark_next, mark_eff;
    logic [23:0] epoch_reg, epoch_next;
    logic        accept;

    assign in_ready       = !q_full;
    assign accept         = in_valid && !q_full;
    assign words_left_dec = words_left_reg - 16'd1;

    always_comb
    begin
        phase_eff = queue_start ? PH_HEADER : phase_reg;
        hidx_eff  = queue_start ? HDR_SIZE : hidx_reg;
        mark_eff  = queue_start ? 1'b0 : mark_reg;

        phase_next      = phase_reg;
        hidx_next       = hidx_reg;
        size_odd_next   = size_odd_reg;
        words_left_next = words_left_reg;
        tdc_next        = tdc_reg;
        trigger_next    = trigger_reg;
        mark_next       = mark_reg;
        epoch_next      = epoch_reg;
        push            = 1'b0;

        push_entry.clear   = 1'b0;
        push_entry.base    = {epoch_reg[20:0], word[10:0]};
        push_entry.fine    = word[21:12];
        push_entry.channel = word[28:22];
        push_entry.rising  = word[11];
        push_entry.tdc     = tdc_reg;
        push_entry.trigger = trigger_reg;
        push_entry.marked  = mark_eff;

        if (accept)
        begin
            phase_next = phase_eff;
            hidx_next  = hidx_eff;
            mark_next  = mark_eff;
            case (phase_eff)
                PH_TDCHDR:
                begin
                    if (word[15:0] == tsh_pkg::TRAILER_ID)
                    begin
                        phase_next = PH_TRAILER;
                    end
                    else if (word[31:16] != 16'd0)
                    begin
                        tdc_next        = word[15:0];
                        words_left_next = word[31:16];
                        phase_next      = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (word[31:28] == tsh_pkg::NIB_HIT)
                    begin
                        push = 1'b1;
                    end
                    else if (word[31:28] == tsh_pkg::NIB_EPOCH)
                    begin
                        epoch_next = word[23:0];
                    end
                    words_left_next = words_left_dec;
                    if (words_left_dec == 16'd0)
                    begin
                        phase_next = PH_TDCHDR;
                    end
                end
                PH_TRAILER:
                begin
                    phase_next = size_odd_reg ? PH_PAD : PH_HEADER;
                    hidx_next  = HDR_SIZE;
                end
                PH_PAD:
                begin
                    phase_next = PH_HEADER;
                    hidx_next  = HDR_SIZE;
                end
                default:
                begin
                    phase_next = PH_HEADER;
                    case (hidx_eff)
                        HDR_SIZE:
                        begin
                            size_odd_next    = word[2];
                            push             = 1'b1;
                            push_entry.clear = 1'b1;
                            hidx_next        = HDR_DECODING;
                        end
                        HDR_DECODING:
                        begin
                            if (word == marking_code)
                            begin
                                mark_next = 1'b1;
                            end
                            hidx_next = HDR_ID;
                        end
                        HDR_ID:
                        begin
                            hidx_next = HDR_TRIGGER;
                        end
                        default:
                        begin
                            trigger_next = word;
                            hidx_next    = HDR_SIZE;
                            phase_next   = PH_TDCHDR;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            hidx_reg       <= HDR_SIZE;
            size_odd_reg   <= 1'b0;
            words_left_reg <= 16'd0;
            tdc_reg        <= 16'd0;
            trigger_reg    <= 32'd0;
            mark_reg       <= 1'b0;
            epoch_reg      <= 24'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hidx_reg       <= hidx_next;
            size_odd_reg   <= size_odd_next;
            words_left_reg <= words_left_next;
            tdc_reg        <= tdc_next;
            trigger_reg    <= trigger_next;
            mark_reg       <= mark_next;
            epoch_reg      <= epoch_next;
        end
    end

endmodule

[sv/tsh_fifo.sv]
// ----------------------------------------------------------------------------
// TDC subevent hit decoder item queue
// Short register queue between the front end and the hit logic.
// ----------------------------------------------------------------------------
module tsh_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tsh_pkg::entry_t      push_entry,
    output logic                 full,
    output logic                 q_valid,
    input  logic                 q_ready,
    output tsh_pkg::entry_t      q_entry
);

    tsh_pkg::entry_t                  slots_reg [tsh_pkg::FIFO_DEPTH];
    logic [tsh_pkg::FIFO_AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [tsh_pkg::FIFO_CW-1:0]      count_reg, count_next;
    logic                             do_pop;

    assign full    = (count_reg == tsh_pkg::FIFO_CW'(tsh_pkg::FIFO_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = slots_reg[rd_ptr_reg];
    assign do_pop  = q_valid && q_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

[sv/tsh_back.sv]
// ----------------------------------------------------------------------------
// TDC subevent hit decoder hit logic
// Computes hit times, tracks reference and held rise, and forms results.
// ----------------------------------------------------------------------------
module tsh_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  tsh_pkg::entry_t      q_entry,
    input  logic [39:0]          time_window,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           hit_kind,
    output logic [15:0]          tdc_ident,
    output logic [6:0]           channel,
    output logic [31:0]          trigger_number,
    output logic signed [41:0]   lead_time,
    output logic signed [41:0]   trail_time,
    output logic signed [41:0]   over_threshold,
    output logic                 is_reference,
    output logic                 marked
);

    logic advance;

    // Stage 1: scaled coarse time
    logic            s1_valid_reg;
    tsh_pkg::entry_t s1_reg;
    logic [40:0]     s1_prod_reg;

    // Stage 2: full hit time
    logic                s2_valid_reg;
    tsh_pkg::entry_t     s2_reg;
    logic signed [41:0]  s2_t_reg;

    // Decision state
    logic signed [41:0] ref_reg, ref_next, ref_upd;
    logic signed [42:0] ref_hi_reg, ref_lo_reg;
    logic signed [41:0] rise_reg, rise_next;
    logic               rise_valid_reg, rise_valid_next;
    logic signed [42:0] t_ext;
    logic               in_win;
    logic               res_valid;
    logic [1:0]         res_kind;
    logic signed [41:0] res_lead, res_trail, res_tot;
    logic               res_ref;
    logic               decide;

    // Output register
    logic               out_valid_reg;
    logic [1:0]         kind_reg;
    logic [15:0]        tdc_reg;
    logic [6:0]         channel_reg;
    logic [31:0]        trigger_reg;
    logic signed [41:0] lead_reg, trail_reg, tot_reg;
    logic               ref_flag_reg, marked_reg;

    assign advance = !out_valid_reg || out_ready;
    assign q_ready = advance;
    assign decide  = advance && s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= q_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg      <= q_entry;
            s1_prod_reg <= {9'd0, q_entry.base} * {32'd0, tsh_pkg::COARSE_SCALE};
            s2_reg      <= s1_reg;
            s2_t_reg    <= $signed({1'b0, s1_prod_reg}) - $signed({32'd0, s1_reg.fine});
        end
    end

    // Window test against precomputed reference bounds
    assign t_ext  = {s2_t_reg[41], s2_t_reg};
    assign in_win = (t_ext < ref_hi_reg) && (t_ext > ref_lo_reg);

    always_comb
    begin
        ref_next        = ref_reg;
        rise_next       = rise_reg;
        rise_valid_next = rise_valid_reg;
        res_valid       = 1'b0;
        res_kind        = tsh_pkg::KIND_PAIRED;
        res_lead        = s2_t_reg;
        res_trail       = s2_t_reg;
        res_tot         = '0;
        res_ref         = 1'b0;

        if (s2_reg.clear)
        begin
            ref_next        = '0;
            rise_next       = '0;
            rise_valid_next = 1'b0;
        end
        else if (s2_reg.channel == 7'd0)
        begin
            ref_next        = s2_t_reg;
            rise_next       = '0;
            rise_valid_next = 1'b0;
            res_ref         = 1'b1;
            if (tsh_pkg::is_tube_ref(s2_reg.tdc))
            begin
                res_valid = 1'b1;
                res_kind  = tsh_pkg::KIND_TUBE_REF;
                res_trail = '0;
            end
            else if (s2_reg.tdc == tsh_pkg::SCI_TDC)
            begin
                res_valid = 1'b1;
                res_kind  = tsh_pkg::KIND_SCI_REF;
            end
        end
        else if (s2_reg.rising && in_win)
        begin
            rise_next       = s2_t_reg;
            rise_valid_next = 1'b1;
            if (s2_reg.tdc == tsh_pkg::SCI_TDC && s2_reg.channel == 7'd1)
            begin
                res_valid = 1'b1;
                res_kind  = tsh_pkg::KIND_SCI_LEAD;
            end
        end
        else if (rise_valid_reg && in_win)
        begin
            res_valid       = 1'b1;
            res_kind        = tsh_pkg::KIND_PAIRED;
            res_lead        = rise_reg;
            res_tot         = s2_t_reg - rise_reg;
            rise_next       = '0;
            rise_valid_next = 1'b0;
        end
    end

    assign ref_upd = decide ? ref_next : ref_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg        <= '0;
            ref_hi_reg     <= '0;
            ref_lo_reg     <= '0;
            rise_reg       <= '0;
            rise_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ref_reg    <= ref_upd;
            // Track the window bounds every cycle so a new window applies at once
            ref_hi_reg <= {ref_upd[41], ref_upd} + {3'b000, time_window};
            ref_lo_reg <= {ref_upd[41], ref_upd} - {3'b000, time_window};
            if (decide)
            begin
                rise_reg       <= rise_next;
                rise_valid_reg <= rise_valid_next;
            end
            if (advance)
            begin
                out_valid_reg <= decide && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (decide && res_valid)
        begin
            kind_reg     <= res_kind;
            tdc_reg      <= s2_reg.tdc;
            channel_reg  <= s2_reg.channel;
            trigger_reg  <= s2_reg.trigger;
            lead_reg     <= res_lead;
            trail_reg    <= res_trail;
            tot_reg      <= res_tot;
            ref_flag_reg <= res_ref;
            marked_reg   <= s2_reg.marked;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit_kind       = kind_reg;
    assign tdc_ident      = tdc_reg;
    assign channel        = channel_reg;
    assign trigger_number = trigger_reg;
    assign lead_time      = lead_reg;
    assign trail_time     = trail_reg;
    assign over_threshold = tot_reg;
    assign is_reference   = ref_flag_reg;
    assign marked         = marked_reg;

endmodule

[sv/tdc_subevent_hit_decoder.sv]
// ----------------------------------------------------------------------------
// TDC subevent hit decoder
// Decodes subevent words into reference, lead and paired edge hits.
// ----------------------------------------------------------------------------
// Takes one subevent word per clock while the queue is not full and gives at
// most one hit per word. The front end walks the framing (header, TDC blocks,
// trailer, padding) and keeps epoch, TDC id, trigger and marking; hit words
// and subevent starts go into a four-item queue. The hit stage multiplies by
// the 500-unit coarse period, subtracts the fine time, then compares against
// the reference window and pairs edges; a hit passes through the queue slot,
// stage 1, stage 2 and the output register. Sustained rate, while the output
// is not stalled, is one word per cycle, set by the single decision stage
// that owns reference time and the held rise. The queue takes new words while
// a result waits at the output; in_ready drops only when the queue is full.
// ----------------------------------------------------------------------------
module tdc_subevent_hit_decoder
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [39:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          word,
    input  logic                 queue_start,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           hit_kind,
    output logic [15:0]          tdc_ident,
    output logic [6:0]           channel,
    output logic [31:0]          trigger_number,
    output logic signed [41:0]   lead_time,
    output logic signed [41:0]   trail_time,
    output logic signed [41:0]   over_threshold,
    output logic                 is_reference,
    output logic                 marked
);

    logic [39:0]     time_window_reg;
    logic [31:0]     marking_code_reg;
    logic            push, q_full, q_valid, q_ready;
    tsh_pkg::entry_t push_entry, q_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_window_reg  <= tsh_pkg::TIME_WINDOW_RST;
            marking_code_reg <= tsh_pkg::MARKING_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tsh_pkg::REG_TIME_WINDOW:  time_window_reg  <= cfg_data;
                tsh_pkg::REG_MARKING_CODE: marking_code_reg <= cfg_data[31:0];
                default:                   time_window_reg  <= time_window_reg;
            endcase
        end
    end

    tsh_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .word         (word),
        .queue_start  (queue_start),
        .marking_code (marking_code_reg),
        .q_full       (q_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    tsh_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_entry    (q_entry)
    );

    tsh_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_entry        (q_entry),
        .time_window    (time_window_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hit_kind       (hit_kind),
        .tdc_ident      (tdc_ident),
        .channel        (channel),
        .trigger_number (trigger_number),
        .lead_time      (lead_time),
        .trail_time     (trail_time),
        .over_threshold (over_threshold),
        .is_reference   (is_reference),
        .marked         (marked)
    );

endmodule

[sv/tsh_checker.sv]
// ----------------------------------------------------------------------------
// TDC subevent hit decoder checker
// Port-level checks on result consistency and output hold.
// ----------------------------------------------------------------------------
`include "tdc_subevent_hit_decoder_macros.svh"

module tsh_checker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [1:0]           hit_kind,
    input  logic [6:0]           channel,
    input  logic signed [41:0]   lead_time,
    input  logic signed [41:0]   trail_time,
    input  logic signed [41:0]   over_threshold,
    input  logic                 is_reference
);

    // A stalled result holds its kind and its lead and trail times
    `TSH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(hit_kind) && $stable(lead_time) && $stable(trail_time),
        "stalled result changed")

    `TSH_ASSERT_NOW(a_ref_kind, out_valid,
        is_reference == (hit_kind == tsh_pkg::KIND_TUBE_REF ||
                         hit_kind == tsh_pkg::KIND_SCI_REF),
        "reference flag disagrees with kind")

    `TSH_ASSERT_NOW(a_tot_zero, out_valid && hit_kind != tsh_pkg::KIND_PAIRED,
        over_threshold == 42'sd0,
        "over-threshold set on unpaired hit")

    `TSH_ASSERT_NOW(a_tube_ref, out_valid && hit_kind == tsh_pkg::KIND_TUBE_REF,
        trail_time == 42'sd0 && channel == 7'd0,
        "tube reference with trail time or non-zero channel")

    `TSH_ASSERT_NOW(a_single_edge,
        out_valid && (hit_kind == tsh_pkg::KIND_SCI_REF ||
                      hit_kind == tsh_pkg::KIND_SCI_LEAD),
        trail_time == lead_time,
        "single-edge hit with differing lead and trail")

endmodule

bind tdc_subevent_hit_decoder tsh_checker u_checker (.*);
